[hdl/azel_pkg.sv]
// Shared types and constants for the az/el slew position tracker.
`default_nettype none

package azel_pkg;

  localparam int AZ_W     = 20;
  localparam int EL_W     = 17;
  localparam int ELAPSED_W = 16;
  localparam int RATE_W   = 10;
  localparam int PROD_W   = ELAPSED_W + RATE_W;
  localparam int STEP_W   = 21;
  localparam int POS_W    = 22;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = RATE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SIMULATE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_RATE       = 1'd1;

  localparam logic [RATE_W-1:0] SLEW_RATE_RESET = 10'd6;

  localparam logic signed [POS_W-1:0] EL_UP_LIMIT  = 22'sd90000;
  localparam logic signed [POS_W-1:0] EL_DOWN_LIMIT = 22'sd0;
  localparam logic signed [POS_W-1:0] AZ_CCW_LIMIT = -22'sd180000;
  localparam logic signed [POS_W-1:0] AZ_CW_LIMIT  = 22'sd180000;
  localparam logic signed [POS_W-1:0] PARK_POS     = 22'sd0;

  typedef enum logic [2:0] {
    CMD_SET   = 3'd0,
    CMD_MOVE  = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_PARK  = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    DIR_UP   = 3'd0,
    DIR_DOWN = 3'd1,
    DIR_CCW  = 3'd2,
    DIR_CW   = 3'd3
  } dir_e;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [AZ_W-1:0]   az_target;
    logic [EL_W-1:0]          el_target;
    logic [2:0]               direction;
    logic [ELAPSED_W-1:0]     elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [AZ_W-1:0] az_now;
    logic [EL_W-1:0]        el_now;
    logic                   moving;
    logic                   moving_az;
    logic                   moving_left;
    logic                   moving_right;
    logic                   moving_el;
    logic                   moving_up;
    logic                   moving_down;
    logic                   error;
  } out_item_t;

  typedef struct packed {
    logic down;
    logic up;
    logic el;
    logic right;
    logic left;
    logic az;
    logic moving;
  } motion_flags_t;

  // Registered transaction plus the saturated step for its elapsed time.
  typedef struct packed {
    cmd_e                   cmd;
    logic signed [AZ_W-1:0] az;
    logic [EL_W-1:0]        el;
    logic [2:0]             dir;
    logic [STEP_W-1:0]      step;
  } stage_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic                    at_goal;
    logic                    rising;
  } axis_res_t;

endpackage

`default_nettype wire

[hdl/azel_in_if.sv]
// Command channel interface: valid/ready with one command item.
`default_nettype none

interface azel_in_if;
  import azel_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/azel_out_if.sv]
// Result channel interface: valid/ready with one position report.
`default_nettype none

interface azel_out_if;
  import azel_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/azel_in_stage.sv]
// Input register stage: captures a command and its saturated slew step.
`default_nettype none

module azel_in_stage (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  azel_pkg::in_item_t           in_data,
  output logic                         in_ready,
  input  wire [azel_pkg::RATE_W-1:0]   slew_rate,
  input  wire                          advance,
  output logic                         stage_valid,
  output azel_pkg::stage_t             stage
);
  import azel_pkg::*;

  logic              valid_r;
  stage_t            stage_r;
  stage_t            stage_nxt;
  logic [PROD_W-1:0] prod;

  assign in_ready    = !valid_r || advance;
  assign stage_valid = valid_r;
  assign stage       = stage_r;

  always_comb begin
    prod = PROD_W'(in_data.elapsed_ms) * PROD_W'(slew_rate);
    stage_nxt.cmd = cmd_e'(in_data.command);
    stage_nxt.az  = in_data.az_target;
    stage_nxt.el  = in_data.el_target;
    stage_nxt.dir = in_data.direction;
    // saturate: any product this large already exceeds every distance
    stage_nxt.step = (|prod[PROD_W-1:STEP_W]) ? '1 : prod[STEP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/azel_axis.sv]
// One axis slew: snap to goal if within step, else step toward it.
`default_nettype none

module azel_axis (
  input  wire signed [azel_pkg::POS_W-1:0]  cur,
  input  wire signed [azel_pkg::POS_W-1:0]  goal,
  input  wire [azel_pkg::STEP_W-1:0]        step,
  output azel_pkg::axis_res_t               res
);
  import azel_pkg::*;

  logic signed [POS_W-1:0] diff;
  logic [POS_W-1:0]        mag;
  logic [POS_W-1:0]        step_x;

  always_comb begin
    diff   = goal - cur;
    mag    = diff[POS_W-1] ? POS_W'(-diff) : POS_W'(diff);
    step_x = POS_W'(step);
    res.at_goal = (mag <= step_x);
    res.rising  = !diff[POS_W-1];
    if (res.at_goal) begin
      res.pos = goal;
    end else if (res.rising) begin
      res.pos = cur + $signed(step_x);
    end else begin
      res.pos = cur - $signed(step_x);
    end
  end

endmodule

`default_nettype wire

[hdl/az_el_slew_position_tracker_top.sv]
// Top level: config registers, axis state, result register and channel control.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+-----------------------------------------
//  in_ch   | in  | valid/ready    | command, az/el target, direction, elapsed
//  out_ch  | out | valid/ready    | az_now, el_now, motion flags, error
//  cfg_*   | in  | cfg_we only    | cfg_idx selects register, cfg_wdata
//
// A command is held in the input register (step multiply), then the state
// update loads the result register. One transaction per cycle unless stalled.
// Each command sees the state left by the one before it.
// A stalled result holds the input register; a new command still enters
// while the input register is empty. Reset (rst_n low, synchronous) zeroes
// positions, goals and flags, and restores slew rate 6 with slewing off.
`default_nettype none

module az_el_slew_position_tracker_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire [azel_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire [azel_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  azel_in_if.sink                             in_ch,
  azel_out_if.source                          out_ch
);
  import azel_pkg::*;

  logic              sim_en_r;
  logic [RATE_W-1:0] slew_rate_r;

  logic signed [AZ_W-1:0] cur_az_r, cur_az_nxt;
  logic signed [AZ_W-1:0] goal_az_r, goal_az_nxt;
  logic [EL_W-1:0]        cur_el_r, cur_el_nxt;
  logic [EL_W-1:0]        goal_el_r, goal_el_nxt;
  motion_flags_t          flags_r, flags_nxt, flags_adv;
  logic                   err_nxt;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic   s1_valid;
  stage_t s1;
  logic   s2_load;

  axis_res_t az_res, el_res;
  logic signed [POS_W-1:0] cur_az_x, goal_az_x, cur_el_x, goal_el_x;

  // goal updates for set, move and park
  logic                    do_set;
  logic signed [POS_W-1:0] set_az, set_el;

  assign s2_load = s1_valid && (!out_valid_r || out_ch.ready);

  azel_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_data     (in_ch.data),
    .in_ready    (in_ch.ready),
    .slew_rate   (slew_rate_r),
    .advance     (s2_load),
    .stage_valid (s1_valid),
    .stage       (s1)
  );

  assign cur_az_x  = POS_W'(cur_az_r);
  assign goal_az_x = POS_W'(goal_az_r);
  assign cur_el_x  = $signed(POS_W'(cur_el_r));
  assign goal_el_x = $signed(POS_W'(goal_el_r));

  azel_axis u_axis_az (
    .cur  (cur_az_x),
    .goal (goal_az_x),
    .step (s1.step),
    .res  (az_res)
  );

  azel_axis u_axis_el (
    .cur  (cur_el_x),
    .goal (goal_el_x),
    .step (s1.step),
    .res  (el_res)
  );

  // flags after one time advance
  always_comb begin
    flags_adv = flags_r;
    if (az_res.at_goal) begin
      flags_adv.az    = 1'b0;
      flags_adv.left  = 1'b0;
      flags_adv.right = 1'b0;
    end else begin
      flags_adv.az = 1'b1;
      if (az_res.rising) begin
        flags_adv.right = 1'b1;
      end else begin
        flags_adv.left = 1'b1;
      end
    end
    if (el_res.at_goal) begin
      flags_adv.el   = 1'b0;
      flags_adv.up   = 1'b0;
      flags_adv.down = 1'b0;
    end else begin
      flags_adv.el = 1'b1;
      if (el_res.rising) begin
        flags_adv.up = 1'b1;
      end else begin
        flags_adv.down = 1'b1;
      end
    end
    flags_adv.moving = flags_adv.az || flags_adv.el;
  end

  always_comb begin
    cur_az_nxt  = cur_az_r;
    goal_az_nxt = goal_az_r;
    cur_el_nxt  = cur_el_r;
    goal_el_nxt = goal_el_r;
    flags_nxt   = flags_r;
    err_nxt     = 1'b0;
    do_set      = 1'b0;
    set_az      = goal_az_x;
    set_el      = goal_el_x;

    unique case (s1.cmd)
      CMD_SET: begin
        do_set = 1'b1;
        set_az = POS_W'(s1.az);
        set_el = $signed(POS_W'(s1.el));
      end
      CMD_MOVE: begin
        unique case (s1.dir)
          DIR_UP: begin
            do_set = 1'b1;
            set_el = EL_UP_LIMIT;
          end
          DIR_DOWN: begin
            do_set = 1'b1;
            set_el = EL_DOWN_LIMIT;
          end
          DIR_CCW: begin
            do_set = 1'b1;
            set_az = AZ_CCW_LIMIT;
          end
          DIR_CW: begin
            do_set = 1'b1;
            set_az = AZ_CW_LIMIT;
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase
      end
      CMD_STOP: begin
        if (sim_en_r && (cur_az_r != goal_az_r || cur_el_r != goal_el_r)) begin
          cur_az_nxt = az_res.pos[AZ_W-1:0];
          cur_el_nxt = el_res.pos[EL_W-1:0];
          flags_nxt  = flags_adv;
        end
        goal_az_nxt = cur_az_nxt;
        goal_el_nxt = cur_el_nxt;
      end
      CMD_PARK: begin
        do_set = 1'b1;
        set_az = PARK_POS;
        set_el = PARK_POS;
      end
      CMD_QUERY: begin
        if (sim_en_r) begin
          cur_az_nxt = az_res.pos[AZ_W-1:0];
          cur_el_nxt = el_res.pos[EL_W-1:0];
          flags_nxt  = flags_adv;
        end
      end
      default: begin
      end
    endcase

    if (do_set) begin
      goal_az_nxt = set_az[AZ_W-1:0];
      goal_el_nxt = set_el[EL_W-1:0];
      if (!sim_en_r) begin
        cur_az_nxt = set_az[AZ_W-1:0];
        cur_el_nxt = set_el[EL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sim_en_r    <= 1'b0;
      slew_rate_r <= SLEW_RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SIMULATE_ENABLE: sim_en_r    <= cfg_wdata[0];
        CFG_SLEW_RATE:       slew_rate_r <= cfg_wdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_az_r  <= '0;
      goal_az_r <= '0;
      cur_el_r  <= '0;
      goal_el_r <= '0;
      flags_r   <= '0;
    end else if (s2_load) begin
      cur_az_r  <= cur_az_nxt;
      goal_az_r <= goal_az_nxt;
      cur_el_r  <= cur_el_nxt;
      goal_el_r <= goal_el_nxt;
      flags_r   <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_data_r.az_now       <= cur_az_nxt;
      out_data_r.el_now       <= cur_el_nxt;
      out_data_r.moving       <= flags_nxt.moving;
      out_data_r.moving_az    <= flags_nxt.az;
      out_data_r.moving_left  <= flags_nxt.left;
      out_data_r.moving_right <= flags_nxt.right;
      out_data_r.moving_el    <= flags_nxt.el;
      out_data_r.moving_up    <= flags_nxt.up;
      out_data_r.moving_down  <= flags_nxt.down;
      out_data_r.error        <= err_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // summary flag always tracks the per-axis flags
  a_moving_summary: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.moving == (flags_r.az || flags_r.el))
    else $error("moving flag out of step with axis flags");

  // a stalled result with a full input register blocks new commands
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && s1_valid) |-> !in_ch.ready)
    else $error("input accepted while pipeline is full");

  // a state update always leaves a result waiting
  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> out_valid_r)
    else $error("state update without a result");

  // an error result only comes from a move command
  a_error_only_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && err_nxt) |-> (s1.cmd == CMD_MOVE))
    else $error("error flagged for a non-move command");

endmodule

`default_nettype wire
